[design/ptfr_pkg.sv]
// ----------------------------------------------------------------------------
// ptfr_pkg: shared types and constants
// Request and status codes, configuration register indexes, port field widths
// and the response word layout of the FIFO page-replacement table.
// ----------------------------------------------------------------------------
package ptfr_pkg;

	// port field widths
	localparam int REQ_TYPE_W = 2;
	localparam int INDEX_W    = 6;
	localparam int STATUS_W   = 3;
	localparam int FRAME_W    = 5;
	localparam int PAGE_W     = 6;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 7;

	// request types
	localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_NONE  = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 3'd6;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_PAGES  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES = 2'd1;

	// response word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame;
		logic [PAGE_W-1:0]   affected_page;
		logic [PAGE_W-1:0]   evicted_page;
		logic                page_used;
		logic                page_dirty;
	} rsp_t;

endpackage

[design/ptfr_if.sv]
// ----------------------------------------------------------------------------
// ptfr_if: channel interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptfr_req_if;
	logic                              valid;
	logic                              ready;
	logic [ptfr_pkg::REQ_TYPE_W-1:0]   req_type;
	logic [ptfr_pkg::INDEX_W-1:0]      index;
	modport source (output valid, output req_type, output index, input ready);
	modport sink   (input valid, input req_type, input index, output ready);
endinterface

interface ptfr_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ptfr_pkg::STATUS_W-1:0]   status;
	logic [ptfr_pkg::FRAME_W-1:0]    frame;
	logic [ptfr_pkg::PAGE_W-1:0]     affected_page;
	logic [ptfr_pkg::PAGE_W-1:0]     evicted_page;
	logic                            page_used;
	logic                            page_dirty;
	modport source (output valid, output status, output frame, output affected_page,
		output evicted_page, output page_used, output page_dirty, input ready);
	modport sink   (input valid, input status, input frame, input affected_page,
		input evicted_page, input page_used, input page_dirty, output ready);
endinterface

interface ptfr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ptfr_pkg::CFG_ADDR_W-1:0]   addr;
	logic [ptfr_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

[design/page_table_fifo_replacement.sv]
// ----------------------------------------------------------------------------
// page_table_fifo_replacement: page table with FIFO page replacement
// Sequencer over three RAMs (page table, free-frame ring, load-order list).
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is low until its response word is
// registered. An out-of-range request goes straight to its response; a hit
// updates the page entry it read, and a load into a free frame pops the
// free-frame ring. A load by eviction reads the head of the load order and
// the victim's entry, then compacts the load-order list one entry a cycle
// through its one read and one write port. A free scans the page table one
// entry a cycle (up to the configured page count) and then searches and
// compacts the load-order list. A response word still held for the sink
// delays the next one until it is taken. A configuration write of the page
// or frame count reinitializes the table; there is no clearing pass,
// per-entry valid bits stand for the reset contents.
module page_table_fifo_replacement #(
	parameter int MAX_PAGES  = 64,
	parameter int MAX_FRAMES = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	ptfr_req_if.sink       req,
	ptfr_rsp_if.source     rsp,
	ptfr_cfg_if.sink       cfg
);

	localparam int PW  = $clog2(MAX_PAGES);
	localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PCW = $clog2(MAX_PAGES + 1);
	localparam int FCW = $clog2(MAX_FRAMES + 1);
	localparam int RST_NP = (64 > MAX_PAGES) ? MAX_PAGES : 64;
	localparam int RST_NF = (32 > MAX_FRAMES) ? MAX_FRAMES : 32;

	typedef struct packed {
		logic          v;
		logic          u;
		logic          d;
		logic [FW-1:0] frame;
	} pte_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RW_CHK, S_RW_POP, S_RW_VIC1, S_RW_VIC2, S_RW_FIN,
		S_FR_SCAN, S_FR_HIT, S_LD_SCAN, S_CMPCT, S_OUT
	} state_t;

	state_t                          state_q;
	logic [ptfr_pkg::REQ_TYPE_W-1:0] type_q;
	logic [ptfr_pkg::INDEX_W-1:0]    idx_q;
	pte_t                            ent_q;
	logic [PW-1:0]                   vic_q;
	logic [PW-1:0]                   page_q;
	logic [FW-1:0]                   frame_q;
	logic [PCW-1:0]                  cnt_q;
	logic                            pend_q;
	logic [PCW-1:0]                  pend_a_q;
	logic [PCW-1:0]                  npages_q;
	logic [FCW-1:0]                  nframes_q;
	logic [FW-1:0]                   head_q;
	logic [FCW-1:0]                  fcnt_q;
	logic [PCW-1:0]                  lcnt_q;
	logic [MAX_PAGES-1:0]            pv_q;
	logic [MAX_FRAMES-1:0]           fqv_q;
	logic [PW-1:0]                   pt_ra_q;
	logic                            fq_vld_q;
	logic [FW-1:0]                   fq_ra_q;
	ptfr_pkg::rsp_t                  res_q;
	ptfr_pkg::rsp_t                  rsp_q;
	logic                            rsp_valid_q;

	// RAM ports
	logic          pt_we, pt_re, fq_we, fq_re, ld_we, ld_re;
	logic [PW-1:0] pt_waddr, pt_raddr, ld_waddr, ld_raddr;
	pte_t          pt_wdata, pt_rdata;
	logic [FW-1:0] fq_waddr, fq_raddr, fq_wdata, fq_rdata;
	logic [PW-1:0] ld_wdata, ld_rdata;

	// decode
	logic          acc, cfg_acc, in_ok, is_wr;
	pte_t          ent_rd;
	logic [FW-1:0] pop_frame, tail, head_nx;
	logic [FCW:0]  tail_sum;
	logic [FCW-1:0] head_inc;
	logic          rw_hit, rw_pop, rw_evict, scan_hit, ld_hit, cmp_done;
	logic          fq_space, ld_space;
	logic [PCW-1:0] cfg_np;

	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign in_ok     = (32'(req.index) < 32'(npages_q)) && (req.req_type != ptfr_pkg::REQ_NONE);
	assign is_wr     = (type_q == ptfr_pkg::REQ_WRITE);

	// entry last read from the page table; never-written entries read as cleared
	assign ent_rd    = pv_q[pt_ra_q] ? pt_rdata : '0;
	assign pop_frame = fq_vld_q ? fq_rdata : fq_ra_q;

	// free ring tail and head wrap
	assign tail_sum = (FCW+1)'(head_q) + (FCW+1)'(fcnt_q);
	assign tail     = (tail_sum >= (FCW+1)'(MAX_FRAMES)) ?
		FW'(tail_sum - (FCW+1)'(MAX_FRAMES)) : FW'(tail_sum);
	assign head_inc = FCW'(head_q) + FCW'(1);
	assign head_nx  = (head_inc >= FCW'(MAX_FRAMES)) ? '0 : FW'(head_inc);
	assign fq_space = (32'(fcnt_q) < 32'(MAX_FRAMES));
	assign ld_space = (32'(lcnt_q) < 32'(MAX_PAGES));

	assign rw_hit   = ent_rd.v;
	assign rw_pop   = !ent_rd.v && (fcnt_q != '0);
	assign rw_evict = !ent_rd.v && (fcnt_q == '0) && (lcnt_q != '0);
	assign scan_hit = pend_q && ent_rd.v && (32'(ent_rd.frame) == 32'(idx_q));
	assign ld_hit   = pend_q && (ld_rdata == page_q);
	assign cmp_done = !pend_q && (cnt_q >= lcnt_q);

	assign cfg_np = (32'(cfg.data) > 32'(MAX_PAGES)) ? PCW'(MAX_PAGES) : PCW'(cfg.data);

	// RAM strobes per sequencer step
	always_comb begin
		pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0; pt_re = 1'b0; pt_raddr = '0;
		fq_we = 1'b0; fq_waddr = '0; fq_wdata = '0; fq_re = 1'b0; fq_raddr = '0;
		ld_we = 1'b0; ld_waddr = '0; ld_wdata = '0; ld_re = 1'b0; ld_raddr = '0;
		case (state_q)
			S_IDLE: begin
				pt_re    = acc;
				pt_raddr = PW'(req.index);
			end
			S_RW_CHK: begin
				if (rw_hit) begin
					pt_we    = 1'b1;
					pt_waddr = PW'(idx_q);
					pt_wdata = '{v: 1'b1, u: 1'b1, d: ent_rd.d | is_wr, frame: ent_rd.frame};
				end else if (rw_pop) begin
					fq_re    = 1'b1;
					fq_raddr = head_q;
				end else if (rw_evict) begin
					ld_re    = 1'b1;
					ld_raddr = '0;
				end
			end
			S_RW_POP: begin
				pt_we    = 1'b1;
				pt_waddr = PW'(idx_q);
				pt_wdata = '{v: 1'b1, u: 1'b1, d: ent_q.d | is_wr, frame: pop_frame};
				ld_we    = ld_space;
				ld_waddr = PW'(lcnt_q);
				ld_wdata = PW'(idx_q);
			end
			S_RW_VIC1: begin
				pt_re    = 1'b1;
				pt_raddr = ld_rdata;
			end
			S_RW_VIC2: begin
				pt_we    = 1'b1;
				pt_waddr = vic_q;
				pt_wdata = '{v: 1'b0, u: 1'b0, d: 1'b0, frame: ent_rd.frame};
			end
			S_RW_FIN: begin
				pt_we    = 1'b1;
				pt_waddr = PW'(idx_q);
				pt_wdata = '{v: 1'b1, u: 1'b1, d: ent_q.d | is_wr, frame: frame_q};
				ld_we    = ld_space;
				ld_waddr = PW'(lcnt_q);
				ld_wdata = PW'(idx_q);
			end
			S_FR_SCAN: begin
				pt_re    = !scan_hit && (cnt_q < npages_q);
				pt_raddr = PW'(cnt_q);
			end
			S_FR_HIT: begin
				pt_we    = 1'b1;
				pt_waddr = page_q;
				pt_wdata = '{v: 1'b0, u: ent_q.u, d: ent_q.d, frame: ent_q.frame};
				fq_we    = fq_space;
				fq_waddr = tail;
				fq_wdata = FW'(idx_q);
			end
			S_LD_SCAN: begin
				ld_re    = !ld_hit && (cnt_q < lcnt_q);
				ld_raddr = PW'(cnt_q);
			end
			S_CMPCT: begin
				// move each entry one place toward the head
				ld_we    = pend_q;
				ld_waddr = PW'(pend_a_q - PCW'(1));
				ld_wdata = ld_rdata;
				ld_re    = (cnt_q < lcnt_q);
				ld_raddr = PW'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer, bookkeeping and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			type_q      <= '0;
			idx_q       <= '0;
			ent_q       <= '0;
			vic_q       <= '0;
			page_q      <= '0;
			frame_q     <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			pend_a_q    <= '0;
			npages_q    <= PCW'(RST_NP);
			nframes_q   <= FCW'(RST_NF);
			head_q      <= '0;
			fcnt_q      <= FCW'(RST_NF);
			lcnt_q      <= '0;
			pv_q        <= '0;
			fqv_q       <= '0;
			pt_ra_q     <= '0;
			fq_vld_q    <= 1'b0;
			fq_ra_q     <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			if (pt_we) begin
				pv_q[pt_waddr] <= 1'b1;
			end
			if (pt_re) begin
				pt_ra_q <= pt_raddr;
			end
			if (fq_we) begin
				fqv_q[fq_waddr] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					// configuration write restarts the table
					if (cfg_acc && (cfg.addr == ptfr_pkg::CFG_PAGES ||
							cfg.addr == ptfr_pkg::CFG_FRAMES)) begin
						if (cfg.addr == ptfr_pkg::CFG_PAGES) begin
							npages_q <= cfg_np;
						end else begin
							nframes_q <= (32'(cfg.data[5:0]) > 32'(MAX_FRAMES)) ?
								FCW'(MAX_FRAMES) : FCW'(cfg.data[5:0]);
							fcnt_q    <= (32'(cfg.data[5:0]) > 32'(MAX_FRAMES)) ?
								FCW'(MAX_FRAMES) : FCW'(cfg.data[5:0]);
						end
						if (cfg.addr == ptfr_pkg::CFG_PAGES) begin
							fcnt_q <= nframes_q;
						end
						pv_q   <= '0;
						fqv_q  <= '0;
						head_q <= '0;
						lcnt_q <= '0;
					end else if (acc) begin
						type_q <= req.req_type;
						idx_q  <= req.index;
						cnt_q  <= '0;
						pend_q <= 1'b0;
						if (!in_ok) begin
							res_q   <= '{status: ptfr_pkg::ST_RANGE, frame: '0,
								affected_page: '0, evicted_page: '0, page_used: 1'b0,
								page_dirty: 1'b0};
							state_q <= S_OUT;
						end else if (req.req_type == ptfr_pkg::REQ_FREE) begin
							state_q <= S_FR_SCAN;
						end else begin
							state_q <= S_RW_CHK;
						end
					end
				end
				S_RW_CHK: begin
					ent_q <= ent_rd;
					if (rw_hit) begin
						res_q   <= '{status: ptfr_pkg::ST_HIT, frame: 5'(ent_rd.frame),
							affected_page: idx_q, evicted_page: '0, page_used: 1'b1,
							page_dirty: ent_rd.d | is_wr};
						state_q <= S_OUT;
					end else if (rw_pop) begin
						fq_vld_q <= fqv_q[head_q];
						fq_ra_q  <= head_q;
						state_q  <= S_RW_POP;
					end else if (rw_evict) begin
						state_q <= S_RW_VIC1;
					end else begin
						res_q   <= '{status: ptfr_pkg::ST_NO_FRAMES, frame: '0,
							affected_page: idx_q, evicted_page: '0, page_used: ent_rd.u,
							page_dirty: ent_rd.d};
						state_q <= S_OUT;
					end
				end
				S_RW_POP: begin
					head_q  <= head_nx;
					fcnt_q  <= fcnt_q - FCW'(1);
					if (ld_space) begin
						lcnt_q <= lcnt_q + PCW'(1);
					end
					res_q   <= '{status: ptfr_pkg::ST_LOADED, frame: 5'(pop_frame),
						affected_page: idx_q, evicted_page: '0, page_used: 1'b1,
						page_dirty: ent_q.d | is_wr};
					state_q <= S_OUT;
				end
				S_RW_VIC1: begin
					vic_q   <= ld_rdata;
					state_q <= S_RW_VIC2;
				end
				S_RW_VIC2: begin
					// drop the head of the load order
					frame_q <= ent_rd.frame;
					cnt_q   <= PCW'(1);
					pend_q  <= 1'b0;
					state_q <= S_CMPCT;
				end
				S_CMPCT: begin
					if (cnt_q < lcnt_q) begin
						pend_q   <= 1'b1;
						pend_a_q <= cnt_q;
						cnt_q    <= cnt_q + PCW'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (cmp_done) begin
						lcnt_q  <= lcnt_q - PCW'(1);
						state_q <= (type_q == ptfr_pkg::REQ_FREE) ? S_OUT : S_RW_FIN;
					end
				end
				S_RW_FIN: begin
					if (ld_space) begin
						lcnt_q <= lcnt_q + PCW'(1);
					end
					res_q   <= '{status: ptfr_pkg::ST_EVICTED, frame: 5'(frame_q),
						affected_page: idx_q, evicted_page: 6'(vic_q), page_used: 1'b1,
						page_dirty: ent_q.d | is_wr};
					state_q <= S_OUT;
				end
				S_FR_SCAN: begin
					// one page entry per cycle; each entry's read is registered before its compare
					if (scan_hit) begin
						ent_q   <= ent_rd;
						page_q  <= PW'(pend_a_q);
						state_q <= S_FR_HIT;
					end else if (cnt_q < npages_q) begin
						pend_q   <= 1'b1;
						pend_a_q <= cnt_q;
						cnt_q    <= cnt_q + PCW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							res_q   <= '{status: ptfr_pkg::ST_NOT_HELD, frame: 5'(idx_q),
								affected_page: '0, evicted_page: '0, page_used: 1'b0,
								page_dirty: 1'b0};
							state_q <= S_OUT;
						end
					end
				end
				S_FR_HIT: begin
					if (fq_space) begin
						fcnt_q <= fcnt_q + FCW'(1);
					end
					res_q   <= '{status: ptfr_pkg::ST_FREED, frame: 5'(idx_q),
						affected_page: 6'(page_q), evicted_page: '0, page_used: ent_q.u,
						page_dirty: ent_q.d};
					cnt_q   <= '0;
					pend_q  <= 1'b0;
					state_q <= S_LD_SCAN;
				end
				S_LD_SCAN: begin
					// find the freed page in the load order
					if (ld_hit) begin
						cnt_q   <= pend_a_q + PCW'(1);
						pend_q  <= 1'b0;
						state_q <= S_CMPCT;
					end else if (cnt_q < lcnt_q) begin
						pend_q   <= 1'b1;
						pend_a_q <= cnt_q;
						cnt_q    <= cnt_q + PCW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response port
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.frame         = rsp_q.frame;
	assign rsp.affected_page = rsp_q.affected_page;
	assign rsp.evicted_page  = rsp_q.evicted_page;
	assign rsp.page_used     = rsp_q.page_used;
	assign rsp.page_dirty    = rsp_q.page_dirty;

	// page table: V, U, D and frame per page
	ptfr_ram #(.W($bits(pte_t)), .D(MAX_PAGES)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	// free-frame ring
	ptfr_ram #(.W(FW), .D(MAX_FRAMES)) u_fq_ram (
		.clk   (clk),
		.we    (fq_we),
		.waddr (fq_waddr),
		.wdata (fq_wdata),
		.re    (fq_re),
		.raddr (fq_raddr),
		.rdata (fq_rdata)
	);

	// load-order list
	ptfr_ram #(.W(PW), .D(MAX_PAGES)) u_ld_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (ld_waddr),
		.wdata (ld_wdata),
		.re    (ld_re),
		.raddr (ld_raddr),
		.rdata (ld_rdata)
	);

`ifndef NO_ASSERTIONS
	// every frame is either free or held by a loaded page
	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> 32'(fcnt_q) + 32'(lcnt_q) == 32'(nframes_q))
		else $error("free plus loaded count differs from frame count");

	// loaded pages never outnumber the configured pages
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lcnt_q) <= 32'(npages_q))
		else $error("load order longer than page count");

	// one request at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");
`endif

endmodule

[design/ptfr_ram.sv]
// ----------------------------------------------------------------------------
// ptfr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptfr_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr,
	input  logic [W-1:0]                          wdata,
	input  logic                                  re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr,
	output logic [W-1:0]                          rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
